// ===== rtl/core/i2cm_pkg.sv =====
// Package: item types, state kinds and constants for the I2C register access master.
`default_nettype none

package i2cm_pkg;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] read_len;
        logic       sda_in;
        logic       scl_in;
    } t_in_item;

    typedef struct packed {
        logic       sda_pull_low;
        logic       scl_pull_low;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       rx_last;
        logic       done_res;
        logic       failed;
        logic       busy_res;
    } t_out_item;

    typedef enum logic [2:0] {
        K_IDLE  = 3'd0,
        K_START = 3'd1,
        K_WBIT  = 3'd2,
        K_WACK  = 3'd3,
        K_RBIT  = 3'd4,
        K_RACK  = 3'd5,
        K_STOP  = 3'd6
    } t_kind;

    localparam logic [1:0] FUNC_NONE  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_PING  = 2'd3;

    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_STRETCH     = 1'b1;

    localparam int         CFG_WIDTH          = 16;
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
    localparam logic [15:0] STRETCH_RESET     = 16'd2000;

endpackage

`default_nettype wire

// ===== rtl/core/i2cm_engine.sv =====
// Bus engine: transaction state and a step from the current item to the next state on each i_step.
`default_nettype none

module i2cm_engine #(
    parameter int TIMER_WIDTH = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_step,
    input  wire i2cm_pkg::t_in_item              i_item,
    input  wire [i2cm_pkg::CFG_WIDTH-1:0]        i_half_period,
    input  wire [i2cm_pkg::CFG_WIDTH-1:0]        i_stretch_timeout,
    output i2cm_pkg::t_out_item                  o_res
);

    localparam int CW = (TIMER_WIDTH > i2cm_pkg::CFG_WIDTH) ? TIMER_WIDTH
                                                            : i2cm_pkg::CFG_WIDTH;
    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

    i2cm_pkg::t_kind          r_kind, n_kind;
    logic [1:0]               r_sub, n_sub;
    logic [3:0]               r_bit, n_bit;
    logic [7:0]               r_shift, n_shift;
    logic [7:0]               r_left, n_left;
    logic [TIMER_WIDTH-1:0]   r_half, n_half;
    logic [TIMER_WIDTH-1:0]   r_st, n_st;
    logic [6:0]               r_addr, n_addr;
    logic [7:0]               r_reg, n_reg;
    logic [7:0]               r_data, n_data;
    logic [1:0]               r_op, n_op;
    logic                     r_nack, n_nack;
    logic                     r_reading, n_reading;

    logic       is_wait;
    logic       leave;
    logic       rx_valid, rx_last, done, fail;
    logic [7:0] rx_byte;
    logic       sda_low, scl_low;

    // next state
    always_comb begin
        n_kind    = r_kind;
        n_sub     = r_sub;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_left    = r_left;
        n_half    = r_half;
        n_st      = r_st;
        n_addr    = r_addr;
        n_reg     = r_reg;
        n_data    = r_data;
        n_op      = r_op;
        n_nack    = r_nack;
        n_reading = r_reading;
        is_wait   = 1'b0;
        leave     = 1'b0;
        rx_valid  = 1'b0;
        rx_last   = 1'b0;
        rx_byte   = 8'd0;
        done      = 1'b0;
        fail      = 1'b0;
        unique case (r_kind)
            i2cm_pkg::K_IDLE: begin
                n_sub = 2'd0;
                if (i_item.func != i2cm_pkg::FUNC_NONE) begin
                    n_op      = i_item.func;
                    n_addr    = i_item.dev_addr;
                    n_reg     = i_item.reg_addr;
                    n_data    = (i_item.func == i2cm_pkg::FUNC_READ) ? i_item.read_len
                                                                     : i_item.write_data;
                    n_left    = (i_item.func == i2cm_pkg::FUNC_WRITE) ? 8'd2 :
                                (i_item.func == i2cm_pkg::FUNC_READ)  ? 8'd1 : 8'd0;
                    n_nack    = 1'b0;
                    n_reading = 1'b0;
                    n_bit     = 4'd0;
                    n_kind    = i2cm_pkg::K_START;
                    n_half    = '0;
                    n_st      = '0;
                end
            end
            i2cm_pkg::K_START, i2cm_pkg::K_WBIT, i2cm_pkg::K_WACK,
            i2cm_pkg::K_RBIT, i2cm_pkg::K_RACK, i2cm_pkg::K_STOP: begin
                is_wait = (r_kind == i2cm_pkg::K_START) ? (r_sub == 2'd0) : (r_sub == 2'd1);
                if (is_wait) begin
                    if (i_item.scl_in) begin
                        leave = 1'b1;
                    end else begin
                        if (r_st != TMAX) begin
                            n_st = r_st + 1'b1;
                        end
                        leave = (CW'(n_st) >= CW'(i_stretch_timeout)) || (n_st == TMAX);
                    end
                end else begin
                    if (r_half != TMAX) begin
                        n_half = r_half + 1'b1;
                    end
                    leave = (CW'(n_half) >= CW'(i_half_period)) || (n_half == TMAX);
                end
                if (leave) begin
                    if (r_sub == 2'd2 && r_kind == i2cm_pkg::K_WACK && i_item.sda_in) begin
                        n_nack = 1'b1;
                    end
                    if (r_sub == 2'd2 && r_kind == i2cm_pkg::K_RBIT) begin
                        n_shift = {r_shift[6:0], i_item.sda_in};
                    end
                    if (!(r_sub == 2'd3 && r_kind == i2cm_pkg::K_STOP)) begin
                        n_half = '0;
                        n_st   = '0;
                    end
                    if (r_sub != 2'd3) begin
                        n_sub = r_sub + 2'd1;
                    end else begin
                        n_sub = 2'd0;
                        unique case (r_kind)
                            i2cm_pkg::K_START: begin
                                n_shift = {r_addr, r_reading};
                                n_bit   = 4'd0;
                                n_kind  = i2cm_pkg::K_WBIT;
                            end
                            i2cm_pkg::K_WBIT: begin
                                n_shift = {r_shift[6:0], 1'b0};
                                n_bit   = r_bit + 4'd1;
                                n_kind  = (n_bit >= 4'd8) ? i2cm_pkg::K_WACK
                                                          : i2cm_pkg::K_WBIT;
                            end
                            i2cm_pkg::K_WACK: begin
                                priority if (r_nack) begin
                                    n_kind = i2cm_pkg::K_STOP;
                                end else if (r_left != 8'd0) begin
                                    n_shift = (r_op == i2cm_pkg::FUNC_WRITE && r_left == 8'd1)
                                              ? r_data : r_reg;
                                    n_left  = r_left - 8'd1;
                                    n_bit   = 4'd0;
                                    n_kind  = i2cm_pkg::K_WBIT;
                                end else if (r_op == i2cm_pkg::FUNC_READ && !r_reading) begin
                                    n_reading = 1'b1;
                                    n_kind    = i2cm_pkg::K_START;
                                end else if (r_op == i2cm_pkg::FUNC_READ) begin
                                    n_left  = r_data;
                                    n_bit   = 4'd0;
                                    n_shift = 8'd0;
                                    n_kind  = (r_data != 8'd0) ? i2cm_pkg::K_RBIT
                                                               : i2cm_pkg::K_STOP;
                                end else begin
                                    n_kind = i2cm_pkg::K_STOP;
                                end
                            end
                            i2cm_pkg::K_RBIT: begin
                                n_bit  = r_bit + 4'd1;
                                n_kind = (n_bit >= 4'd8) ? i2cm_pkg::K_RACK
                                                         : i2cm_pkg::K_RBIT;
                            end
                            i2cm_pkg::K_RACK: begin
                                rx_valid = 1'b1;
                                rx_byte  = r_shift;
                                rx_last  = (r_left <= 8'd1);
                                n_left   = (r_left != 8'd0) ? r_left - 8'd1 : 8'd0;
                                n_bit    = 4'd0;
                                n_shift  = 8'd0;
                                n_kind   = (n_left != 8'd0) ? i2cm_pkg::K_RBIT
                                                            : i2cm_pkg::K_STOP;
                            end
                            i2cm_pkg::K_STOP: begin
                                done   = 1'b1;
                                fail   = r_nack;
                                n_kind = i2cm_pkg::K_IDLE;
                            end
                            default: begin
                                n_kind = i2cm_pkg::K_IDLE;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_kind = i2cm_pkg::K_IDLE;
                n_sub  = 2'd0;
            end
        endcase
    end

    // bus drive after this tick's update
    always_comb begin
        sda_low = 1'b0;
        scl_low = 1'b0;
        unique case (n_kind)
            i2cm_pkg::K_START: begin
                sda_low = (n_sub >= 2'd2);
                scl_low = (n_sub == 2'd3);
            end
            i2cm_pkg::K_STOP: begin
                sda_low = (n_sub != 2'd3);
                scl_low = (n_sub == 2'd0);
            end
            i2cm_pkg::K_WBIT: begin
                sda_low = !n_shift[7];
                scl_low = (n_sub == 2'd0) || (n_sub == 2'd3);
            end
            i2cm_pkg::K_RACK: begin
                sda_low = (n_sub != 2'd3) && (n_left > 8'd1);
                scl_low = (n_sub == 2'd0) || (n_sub == 2'd3);
            end
            i2cm_pkg::K_WACK, i2cm_pkg::K_RBIT: begin
                scl_low = (n_sub == 2'd0) || (n_sub == 2'd3);
            end
            default: begin
                sda_low = 1'b0;
                scl_low = 1'b0;
            end
        endcase
        o_res.sda_pull_low = sda_low;
        o_res.scl_pull_low = scl_low;
        o_res.rx_byte      = rx_byte;
        o_res.rx_valid     = rx_valid;
        o_res.rx_last      = rx_last;
        o_res.done_res     = done;
        o_res.failed       = fail;
        o_res.busy_res     = (n_kind != i2cm_pkg::K_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= i2cm_pkg::K_IDLE;
            r_sub     <= 2'd0;
            r_bit     <= 4'd0;
            r_shift   <= 8'd0;
            r_left    <= 8'd0;
            r_half    <= '0;
            r_st      <= '0;
            r_addr    <= 7'd0;
            r_reg     <= 8'd0;
            r_data    <= 8'd0;
            r_op      <= 2'd0;
            r_nack    <= 1'b0;
            r_reading <= 1'b0;
        end else if (i_step) begin
            r_kind    <= n_kind;
            r_sub     <= n_sub;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_left    <= n_left;
            r_half    <= n_half;
            r_st      <= n_st;
            r_addr    <= n_addr;
            r_reg     <= n_reg;
            r_data    <= n_data;
            r_op      <= n_op;
            r_nack    <= n_nack;
            r_reading <= n_reading;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/i2c_master_register_access_unit.sv =====
// Top level: I2C register access master with item input register, result register, config.
// An accepted item waits in the input register; its result is offered from the result register.
// Throughput: one item per cycle unless the result side stalls; the engine steps once per item.
// Stalls on the result side hold the input register and block new items only when both are full.
// Reset (synchronous, active low): engine idle with both lines released, registers at
// half period 5 and stretch timeout 2000, both stages empty.
`default_nettype none

module i2c_master_register_access_unit #(
    parameter int TIMER_WIDTH = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire                                i_cfg_idx,
    input  wire [i2cm_pkg::CFG_WIDTH-1:0]      i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire i2cm_pkg::t_in_item            i_in_item,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output i2cm_pkg::t_out_item                o_out_item
);

    logic [i2cm_pkg::CFG_WIDTH-1:0] r_half_period;
    logic [i2cm_pkg::CFG_WIDTH-1:0] r_stretch_timeout;
    logic                           r_in_valid;
    i2cm_pkg::t_in_item             r_in_item;
    logic                           r_out_valid;
    i2cm_pkg::t_out_item            r_out_item;
    i2cm_pkg::t_out_item            step_res;
    logic                           advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    i2cm_engine #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (advance),
        .i_item           (r_in_item),
        .i_half_period    (r_half_period),
        .i_stretch_timeout(r_stretch_timeout),
        .o_res            (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period     <= i2cm_pkg::HALF_PERIOD_RESET;
            r_stretch_timeout <= i2cm_pkg::STRETCH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                i2cm_pkg::CFG_HALF_PERIOD: r_half_period     <= i_cfg_data;
                i2cm_pkg::CFG_STRETCH:     r_stretch_timeout <= i_cfg_data;
                default:                   r_half_period     <= r_half_period;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= step_res;
        end
    end

endmodule

`default_nettype wire
